[design/pulse_window_sum_difference_defines.svh]
// Assertion macros for the pulse window sum/difference checker.
`ifndef PULSE_WINDOW_SUM_DIFFERENCE_DEFINES_SVH
`define PULSE_WINDOW_SUM_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PWSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PWSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pwsd_pkg.sv]
package pwsd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_RADIUS   = 16;
    localparam int MAX_BINS     = 1024;

    localparam int SLOT_COUNT = 2 * MAX_RADIUS;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int HELD_W     = $clog2(SLOT_COUNT + 1);
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int LEN_W      = $clog2(MAX_BINS + 1);
    localparam int SUM_W      = SAMPLE_WIDTH + $clog2(MAX_RADIUS);
    localparam int DIFF_W     = SUM_W + 1;
    localparam int HIST_AW    = SLOT_W + BIN_W;
    localparam int HIST_DEPTH = 2 ** HIST_AW;

    localparam int DIFF_LIMIT = MAX_RADIUS * (2 ** (SAMPLE_WIDTH - 1))
                              + MAX_RADIUS * (2 ** (SAMPLE_WIDTH - 1) - 1);

    // configuration port
    localparam int RADIUS_W  = 5;
    localparam int LENGTH_W  = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH = CFG_IDX_W'(1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(4);
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(1024);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [BIN_W-1:0]               bin;
        logic [SLOT_W-1:0]              head;
        logic [SLOT_W-1:0]              rslot;
        logic                           has_r;
        logic                           has_2r;
        logic                           first;
        logic                           emit;
        logic                           last;
    } pwsd_s1_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] old_sum;
        logic signed [SUM_W-1:0] new_sum;
        logic                    emit;
        logic                    last;
    } pwsd_s3_t;

endpackage

[design/pwsd_sample_if.sv]
interface pwsd_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pwsd_pkg::SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[design/pwsd_result_if.sv]
interface pwsd_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pwsd_pkg::DIFF_W-1:0] difference;
    logic                               pulse_end;

    modport source (output valid, output difference, output pulse_end, input ready);
    modport sink (input valid, input difference, input pulse_end, output ready);
endinterface

[design/pulse_window_sum_difference.sv]
// Throughput: one sample per cycle unless the output stalls; four register
// stages (address/counters, memory read, sum update and write-back,
// difference/output register). Reset clears counters, stage valids and
// forwarding flags; sum memories need no clearing pass, the first pulse
// after reset or a register write reads zero.
module pulse_window_sum_difference (
    input  logic                           clk,
    input  logic                           rst_n,
    pwsd_sample_if.sink                    video,
    pwsd_result_if.source                  result,
    input  logic                           cfg_write,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pwsd_pkg::CFG_W-1:0]     cfg_data
);

    logic                 accept;
    logic                 s1_valid;
    logic                 s1_go;
    logic                 s2_free;
    logic                 s3_valid;
    logic                 s3_go;
    logic                 out_free;
    pwsd_pkg::pwsd_s1_t   s1;
    pwsd_pkg::pwsd_s3_t   s3;

    logic                               out_valid_reg, out_valid_next;
    logic signed [pwsd_pkg::DIFF_W-1:0] diff_reg;
    logic                               pulse_end_reg;

    assign out_free    = !out_valid_reg || result.ready;
    assign s3_go       = s3_valid && (!s3.emit || out_free);
    assign s1_go       = s1_valid && s2_free;
    assign video.ready = !s1_valid || s1_go;
    assign accept      = video.valid && video.ready;

    pwsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (video.sample),
        .s1_go     (s1_go),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    pwsd_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_go    (s1_go),
        .s1       (s1),
        .s3_go    (s3_go),
        .s2_free  (s2_free),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    always_comb
    begin
        if (s3_go && s3.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s3_go && s3.emit)
        begin
            diff_reg      <= pwsd_pkg::DIFF_W'(s3.old_sum) - pwsd_pkg::DIFF_W'(s3.new_sum);
            pulse_end_reg <= s3.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.difference = diff_reg;
    assign result.pulse_end  = pulse_end_reg;

endmodule

[design/pwsd_ram.sv]
module pwsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/pwsd_front.sv]
module pwsd_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pwsd_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                     accept,
    input  logic signed [pwsd_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic                                     s1_go,
    output logic                                     s1_valid,
    output pwsd_pkg::pwsd_s1_t                       s1
);

    logic [pwsd_pkg::RADIUS_W-1:0] radius_reg, radius_next;
    logic [pwsd_pkg::LENGTH_W-1:0] length_reg, length_next;
    logic [pwsd_pkg::HELD_W-1:0]   held_reg, held_next;
    logic [pwsd_pkg::BIN_W-1:0]    bin_reg, bin_next;
    logic [pwsd_pkg::SLOT_W-1:0]   head_reg, head_next;
    logic                          s1_valid_reg, s1_valid_next;
    pwsd_pkg::pwsd_s1_t            s1_reg, s1_next;

    logic [pwsd_pkg::RAD_W-1:0]  r_eff;
    logic [pwsd_pkg::LEN_W-1:0]  len_eff;
    logic [pwsd_pkg::HELD_W-1:0] ring;
    logic [pwsd_pkg::HELD_W-1:0] rslot_sum;
    logic [pwsd_pkg::HELD_W-1:0] head_inc;
    logic [pwsd_pkg::SLOT_W-1:0] rslot;
    logic                        last;
    logic                        emit;

    // clamp registers to legal range
    always_comb
    begin
        if (radius_reg == '0)
            r_eff = pwsd_pkg::RAD_W'(1);
        else if (32'(radius_reg) > pwsd_pkg::MAX_RADIUS)
            r_eff = pwsd_pkg::RAD_W'(pwsd_pkg::MAX_RADIUS);
        else
            r_eff = pwsd_pkg::RAD_W'(radius_reg);

        if (length_reg == '0)
            len_eff = pwsd_pkg::LEN_W'(1);
        else if (32'(length_reg) > pwsd_pkg::MAX_BINS)
            len_eff = pwsd_pkg::LEN_W'(pwsd_pkg::MAX_BINS);
        else
            len_eff = pwsd_pkg::LEN_W'(length_reg);
    end

    always_comb
    begin
        ring      = pwsd_pkg::HELD_W'(r_eff) << 1;
        rslot_sum = pwsd_pkg::HELD_W'(head_reg) + pwsd_pkg::HELD_W'(r_eff);
        rslot     = (rslot_sum >= ring) ? pwsd_pkg::SLOT_W'(rslot_sum - ring)
                                        : pwsd_pkg::SLOT_W'(rslot_sum);
        head_inc  = pwsd_pkg::HELD_W'(head_reg) + pwsd_pkg::HELD_W'(1);
        last      = (pwsd_pkg::LEN_W'(bin_reg) + pwsd_pkg::LEN_W'(1)) >= len_eff;
        emit      = (held_reg + pwsd_pkg::HELD_W'(1)) >= ring;
    end

    always_comb
    begin
        radius_next = radius_reg;
        length_next = length_reg;
        held_next   = held_reg;
        bin_next    = bin_reg;
        head_next   = head_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pwsd_pkg::REG_RADIUS:
                    radius_next = pwsd_pkg::RADIUS_W'(cfg_data);
                pwsd_pkg::REG_PULSE_LENGTH:
                    length_next = pwsd_pkg::LENGTH_W'(cfg_data);
                default:
                begin
                end
            endcase
            held_next = '0;
            bin_next  = '0;
            head_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                bin_next  = '0;
                head_next = (head_inc >= ring) ? '0 : pwsd_pkg::SLOT_W'(head_inc);
                if (held_reg < ring)
                    held_next = held_reg + pwsd_pkg::HELD_W'(1);
            end
            else
            begin
                bin_next = bin_reg + pwsd_pkg::BIN_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.sample = sample;
            s1_next.bin    = bin_reg;
            s1_next.head   = head_reg;
            s1_next.rslot  = rslot;
            s1_next.has_r  = held_reg >= pwsd_pkg::HELD_W'(r_eff);
            s1_next.has_2r = held_reg >= ring;
            s1_next.first  = held_reg == '0;
            s1_next.emit   = emit;
            s1_next.last   = last;
        end
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= pwsd_pkg::RADIUS_RESET;
            length_reg   <= pwsd_pkg::LENGTH_RESET;
            held_reg     <= '0;
            bin_reg      <= '0;
            head_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            radius_reg   <= radius_next;
            length_reg   <= length_next;
            held_reg     <= held_next;
            bin_reg      <= bin_next;
            head_reg     <= head_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

[design/pwsd_accum.sv]
module pwsd_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_go,
    input  pwsd_pkg::pwsd_s1_t s1,
    input  logic               s3_go,
    output logic               s2_free,
    output logic               s3_valid,
    output pwsd_pkg::pwsd_s3_t s3
);

    logic                  s2_valid_reg, s2_valid_next;
    pwsd_pkg::pwsd_s1_t    s2_reg;
    logic                  fwd_sum_reg, fwd_hr_reg, fwd_h2r_reg;
    logic                  s3_valid_reg, s3_valid_next;
    pwsd_pkg::pwsd_s3_t    s3_reg;
    logic signed [pwsd_pkg::SUM_W-1:0]        lw_old_reg, lw_new_reg;
    logic signed [pwsd_pkg::SAMPLE_WIDTH-1:0] lw_sample_reg;

    logic                                s2_go;
    logic [pwsd_pkg::SAMPLE_WIDTH-1:0]   hr_rd, h2r_rd;
    logic [pwsd_pkg::SUM_W-1:0]          old_rd, new_rd;
    logic [pwsd_pkg::HIST_AW-1:0]        hist_wr_addr;
    logic signed [pwsd_pkg::SAMPLE_WIDTH-1:0] h_r, h_2r;
    logic signed [pwsd_pkg::SUM_W-1:0]   old_prev, new_prev;
    logic signed [pwsd_pkg::SUM_W-1:0]   old_upd, new_upd;

    assign s2_go        = s2_valid_reg && (!s3_valid_reg || s3_go);
    assign s2_free      = !s2_valid_reg || s2_go;
    assign hist_wr_addr = {s2_reg.head, s2_reg.bin};

    // two copies of the history so both window edges read in the same cycle
    pwsd_ram #(
        .WIDTH (pwsd_pkg::SAMPLE_WIDTH),
        .DEPTH (pwsd_pkg::HIST_DEPTH)
    ) u_hist_r (
        .clk     (clk),
        .wr_en   (s2_go),
        .wr_addr (hist_wr_addr),
        .wr_data (s2_reg.sample),
        .rd_en   (s1_go),
        .rd_addr ({s1.rslot, s1.bin}),
        .rd_data (hr_rd)
    );

    pwsd_ram #(
        .WIDTH (pwsd_pkg::SAMPLE_WIDTH),
        .DEPTH (pwsd_pkg::HIST_DEPTH)
    ) u_hist_2r (
        .clk     (clk),
        .wr_en   (s2_go),
        .wr_addr (hist_wr_addr),
        .wr_data (s2_reg.sample),
        .rd_en   (s1_go),
        .rd_addr ({s1.head, s1.bin}),
        .rd_data (h2r_rd)
    );

    pwsd_ram #(
        .WIDTH (pwsd_pkg::SUM_W),
        .DEPTH (pwsd_pkg::MAX_BINS)
    ) u_old_sums (
        .clk     (clk),
        .wr_en   (s2_go),
        .wr_addr (s2_reg.bin),
        .wr_data (old_upd),
        .rd_en   (s1_go),
        .rd_addr (s1.bin),
        .rd_data (old_rd)
    );

    pwsd_ram #(
        .WIDTH (pwsd_pkg::SUM_W),
        .DEPTH (pwsd_pkg::MAX_BINS)
    ) u_new_sums (
        .clk     (clk),
        .wr_en   (s2_go),
        .wr_addr (s2_reg.bin),
        .wr_data (new_upd),
        .rd_en   (s1_go),
        .rd_addr (s1.bin),
        .rd_data (new_rd)
    );

    // first pulse after clear reads sums as zero; the previous item's
    // write is forwarded when it landed on the same cycle as our read
    always_comb
    begin
        if (!s2_reg.has_r)
            h_r = '0;
        else if (fwd_hr_reg)
            h_r = lw_sample_reg;
        else
            h_r = $signed(hr_rd);

        if (!s2_reg.has_2r)
            h_2r = '0;
        else if (fwd_h2r_reg)
            h_2r = lw_sample_reg;
        else
            h_2r = $signed(h2r_rd);

        if (s2_reg.first)
        begin
            old_prev = '0;
            new_prev = '0;
        end
        else if (fwd_sum_reg)
        begin
            old_prev = lw_old_reg;
            new_prev = lw_new_reg;
        end
        else
        begin
            old_prev = $signed(old_rd);
            new_prev = $signed(new_rd);
        end

        new_upd = new_prev + pwsd_pkg::SUM_W'(s2_reg.sample) - pwsd_pkg::SUM_W'(h_r);
        old_upd = old_prev + pwsd_pkg::SUM_W'(h_r) - pwsd_pkg::SUM_W'(h_2r);
    end

    always_comb
    begin
        if (s1_go)
            s2_valid_next = 1'b1;
        else if (s2_go)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        if (s2_go)
            s3_valid_next = 1'b1;
        else if (s3_go)
            s3_valid_next = 1'b0;
        else
            s3_valid_next = s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd_sum_reg  <= 1'b0;
            fwd_hr_reg   <= 1'b0;
            fwd_h2r_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            if (s1_go)
            begin
                fwd_sum_reg <= s2_go && (s2_reg.bin == s1.bin);
                fwd_hr_reg  <= s2_go && (hist_wr_addr == {s1.rslot, s1.bin});
                fwd_h2r_reg <= s2_go && (hist_wr_addr == {s1.head, s1.bin});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_reg <= s1;
        end
        if (s2_go)
        begin
            lw_old_reg     <= old_upd;
            lw_new_reg     <= new_upd;
            lw_sample_reg  <= s2_reg.sample;
            s3_reg.old_sum <= old_upd;
            s3_reg.new_sum <= new_upd;
            s3_reg.emit    <= s2_reg.emit;
            s3_reg.last    <= s2_reg.last;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3       = s3_reg;

endmodule

[design/pwsd_checker.sv]
`include "pulse_window_sum_difference_defines.svh"

module pwsd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [pwsd_pkg::DIFF_W-1:0] out_difference,
    input logic                               out_pulse_end
);

    `PWSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `PWSD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_difference) && $stable(out_pulse_end), "result changed while stalled")
    `PWSD_ASSERT_NOW(a_no_backpressure, !out_valid || out_ready, in_ready, "input stalled with free output")
    `PWSD_ASSERT_NOW(a_diff_range, out_valid, out_difference >= -pwsd_pkg::DIFF_LIMIT && out_difference <= pwsd_pkg::DIFF_LIMIT, "difference out of range")

endmodule

bind pulse_window_sum_difference pwsd_checker u_pwsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (video.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_difference (result.difference),
    .out_pulse_end  (result.pulse_end)
);
